[hdl/dpbt_pkg.sv]
package dpbt_pkg;

    // operation codes of a request
    localparam logic [1:0] OP_LOAD_PENALTY = 2'd0;
    localparam logic [1:0] OP_SAMPLE       = 2'd1;
    localparam logic [1:0] OP_FETCH        = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_GAP_MIN  = 2'd0;
    localparam logic [1:0] CFG_GAP_MAX  = 2'd1;
    localparam logic [1:0] CFG_TAIL_LEN = 2'd2;

    // configuration reset values
    localparam logic [7:0] GAP_MIN_RST  = 8'd31;
    localparam logic [7:0] GAP_MAX_RST  = 8'd83;
    localparam logic [8:0] TAIL_LEN_RST = 9'd103;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  gap;
        logic [23:0] value;
        logic        last;
    } dpbt_req_t;

    typedef struct packed {
        logic [11:0] beat_frame;
        logic        last_beat;
        logic        none_left;
    } dpbt_res_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_pen;
        logic fetch;
        logic frame_init;
        logic scan_issue;
        logic write_frame;
        logic tail_init;
        logic bt_start;
        logic bt_write;
        logic bt_next;
        logic track_done;
    } dpbt_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic frame_full;
        logic scan_empty;
        logic scan_end;
        logic bp_none;
    } dpbt_status_t;

endpackage

[hdl/dpbt_ctrl.sv]
module dpbt_ctrl
    import dpbt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  dpbt_req_t    request,
    input  dpbt_status_t status,
    output dpbt_cmd_t    cmd,
    output logic         busy
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE,
        ST_TAIL_INIT,
        ST_TAIL_SCAN,
        ST_TAIL_DRAIN,
        ST_BT_START,
        ST_BT_RD,
        ST_BT_WAIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   last_reg;
    logic   last_next;
    logic   busy_reg;

    // next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        last_next  = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (request.operation)
                        OP_LOAD_PENALTY:
                        begin
                            cmd.load_pen = 1'b1;
                        end
                        OP_SAMPLE:
                        begin
                            last_next = request.last;
                            if (!status.frame_full)
                            begin
                                cmd.frame_init = 1'b1;
                                state_next     = ST_SCAN;
                            end
                            else if (request.last)
                            begin
                                state_next = ST_TAIL_INIT;
                            end
                        end
                        OP_FETCH:
                        begin
                            cmd.fetch = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (status.scan_empty)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cmd.scan_issue = 1'b1;
                    if (status.scan_end)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.write_frame = 1'b1;
                state_next      = last_reg ? ST_TAIL_INIT : ST_IDLE;
            end
            ST_TAIL_INIT:
            begin
                cmd.tail_init = 1'b1;
                state_next    = ST_TAIL_SCAN;
            end
            ST_TAIL_SCAN:
            begin
                if (status.scan_empty)
                begin
                    state_next = ST_TAIL_DRAIN;
                end
                else
                begin
                    cmd.scan_issue = 1'b1;
                    if (status.scan_end)
                    begin
                        state_next = ST_TAIL_DRAIN;
                    end
                end
            end
            ST_TAIL_DRAIN:
            begin
                state_next = ST_BT_START;
            end
            ST_BT_START:
            begin
                cmd.bt_start = 1'b1;
                state_next   = ST_BT_RD;
            end
            ST_BT_RD:
            begin
                cmd.bt_write = 1'b1;
                state_next   = ST_BT_WAIT;
            end
            ST_BT_WAIT:
            begin
                if (status.bp_none)
                begin
                    cmd.track_done = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    cmd.bt_next = 1'b1;
                    state_next  = ST_BT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
            busy_reg  <= (state_next != ST_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

[hdl/dpbt_datapath.sv]
module dpbt_datapath
    import dpbt_pkg::*;
#(
    parameter int MAX_FRAMES = 4096,
    parameter int MAX_GAP    = 256
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  dpbt_cmd_t    cmd,
    output dpbt_status_t status,
    input  dpbt_req_t    request,
    input  logic         cfg_write,
    input  logic [1:0]   cfg_index,
    input  logic [8:0]   cfg_data,
    output logic         result_valid,
    output dpbt_res_t    result
);

    localparam int FW  = $clog2(MAX_FRAMES);
    localparam int FCW = FW + 1;
    localparam int PW  = $clog2(MAX_GAP);

    // configuration
    logic [7:0] gap_min_reg;
    logic [7:0] gap_max_reg;
    logic [8:0] tail_len_reg;

    // track state
    logic [FCW-1:0] frame_count_reg;
    logic [FCW-1:0] beat_count_reg;
    logic [FCW-1:0] read_ptr_reg;
    logic [23:0]    env_reg;

    // scan sequencer
    logic [FW-1:0] j_cur_reg;
    logic [FW-1:0] j_end_reg;
    logic          scan_empty_reg;
    logic          tail_mode_reg;

    // read stage
    logic          rd_valid_reg;
    logic          rd_first_reg;
    logic          rd_tail_reg;
    logic [FW-1:0] rd_j_reg;

    // running best
    logic [31:0]   best_val_reg;
    logic [FW-1:0] best_j_reg;
    logic          best_found_reg;

    // backtrack
    logic [FW-1:0]  bt_p_reg;
    logic [FCW-1:0] bt_cnt_reg;

    // result
    logic out_valid_reg;
    logic out_none_reg;
    logic out_last_reg;

    // memories
    logic [23:0]   pen_mem   [MAX_GAP];
    logic [31:0]   score_mem [MAX_FRAMES];
    logic [FW:0]   bp_mem    [MAX_FRAMES];
    logic [FW-1:0] bl_mem    [MAX_FRAMES];
    logic [23:0]   pen_q;
    logic [31:0]   score_q;
    logic [FW:0]   bp_q;
    logic [FW-1:0] bl_q;

    logic          gap_ok;
    logic [7:0]    lo_val;
    logic [7:0]    dhi_val;
    logic          dp_empty;
    logic [FW-1:0] dp_jlo;
    logic [FW-1:0] dp_jhi;
    logic [FCW-1:0] tail_start;
    logic [FW-1:0] last_idx;
    logic [FW-1:0] score_addr;
    logic [PW-1:0] pen_addr;
    logic [FW-1:0] bl_addr;
    logic [32:0]   cand;
    logic          take;
    logic [32:0]   sum;
    logic [31:0]   score_wr;
    logic          has_beat;

    // scan range for a new frame
    always_comb
    begin
        lo_val  = (gap_min_reg == 8'd0) ? 8'd1 : gap_min_reg;
        dhi_val = gap_max_reg;
        if (32'(frame_count_reg) < 32'(gap_max_reg))
        begin
            dhi_val = 8'(frame_count_reg);
        end
        if (32'(MAX_GAP - 1) < 32'(dhi_val))
        begin
            dhi_val = 8'(MAX_GAP - 1);
        end
        dp_empty = (dhi_val < lo_val);
        dp_jlo   = FW'(32'(frame_count_reg) - 32'(dhi_val));
        dp_jhi   = FW'(32'(frame_count_reg) - 32'(lo_val));
    end

    // tail window over the stored frames
    always_comb
    begin
        if (32'(frame_count_reg) > 32'(tail_len_reg))
        begin
            tail_start = FCW'(32'(frame_count_reg) - 32'(tail_len_reg));
        end
        else
        begin
            tail_start = '0;
        end
        last_idx = FW'(32'(frame_count_reg) - 32'd1);
    end

    assign gap_ok     = (32'(request.gap) < 32'(MAX_GAP));
    assign score_addr = cmd.tail_init ? last_idx : j_cur_reg;
    assign pen_addr   = PW'(32'(frame_count_reg) - 32'(j_cur_reg));
    assign bl_addr    = FW'(beat_count_reg - read_ptr_reg - FCW'(1));
    assign has_beat   = (read_ptr_reg < beat_count_reg);

    // candidate compare: score minus penalty (no penalty in the tail) against the running best
    assign cand = {1'b0, score_q} - {9'b0, (rd_tail_reg ? 24'd0 : pen_q)};
    assign take = rd_valid_reg
                  && (rd_first_reg || (!cand[32] && (cand[31:0] > best_val_reg)));

    // saturating score of the current frame
    assign sum      = {9'b0, env_reg} + {1'b0, best_val_reg};
    assign score_wr = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

    // penalty table
    always_ff @(posedge clk)
    begin
        if (cmd.load_pen && gap_ok)
        begin
            pen_mem[PW'(request.gap)] <= request.value;
        end
        pen_q <= pen_mem[pen_addr];
    end

    // score store
    always_ff @(posedge clk)
    begin
        if (cmd.write_frame)
        begin
            score_mem[FW'(frame_count_reg)] <= score_wr;
        end
        score_q <= score_mem[score_addr];
    end

    // back pointers, msb marks no predecessor
    always_ff @(posedge clk)
    begin
        if (cmd.write_frame)
        begin
            bp_mem[FW'(frame_count_reg)] <= {!best_found_reg, best_j_reg};
        end
        bp_q <= bp_mem[bt_p_reg];
    end

    // beat list, stored newest first
    always_ff @(posedge clk)
    begin
        if (cmd.bt_write)
        begin
            bl_mem[FW'(bt_cnt_reg)] <= bt_p_reg;
        end
        bl_q <= bl_mem[bl_addr];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_min_reg  <= GAP_MIN_RST;
            gap_max_reg  <= GAP_MAX_RST;
            tail_len_reg <= TAIL_LEN_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_GAP_MIN:  gap_min_reg  <= cfg_data[7:0];
                CFG_GAP_MAX:  gap_max_reg  <= cfg_data[7:0];
                CFG_TAIL_LEN: tail_len_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // control state of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= '0;
            beat_count_reg  <= '0;
            read_ptr_reg    <= '0;
            scan_empty_reg  <= 1'b0;
            tail_mode_reg   <= 1'b0;
            rd_valid_reg    <= 1'b0;
            rd_first_reg    <= 1'b0;
            rd_tail_reg     <= 1'b0;
            best_found_reg  <= 1'b0;
            bt_cnt_reg      <= '0;
            out_valid_reg   <= 1'b0;
            out_none_reg    <= 1'b0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            rd_valid_reg  <= cmd.scan_issue || cmd.tail_init;
            rd_first_reg  <= cmd.tail_init;
            rd_tail_reg   <= cmd.tail_init || tail_mode_reg;
            out_valid_reg <= cmd.fetch;

            if (cmd.frame_init)
            begin
                scan_empty_reg <= dp_empty;
                tail_mode_reg  <= 1'b0;
                best_found_reg <= 1'b0;
            end
            if (cmd.tail_init)
            begin
                scan_empty_reg <= (tail_len_reg == 9'd0);
                tail_mode_reg  <= 1'b1;
                bt_cnt_reg     <= '0;
            end
            if (take)
            begin
                best_found_reg <= 1'b1;
            end
            if (cmd.write_frame)
            begin
                frame_count_reg <= frame_count_reg + FCW'(1);
            end
            if (cmd.bt_start)
            begin
                bt_cnt_reg <= '0;
            end
            if (cmd.bt_write)
            begin
                bt_cnt_reg <= bt_cnt_reg + FCW'(1);
            end
            if (cmd.track_done)
            begin
                beat_count_reg  <= bt_cnt_reg;
                read_ptr_reg    <= '0;
                frame_count_reg <= '0;
            end
            if (cmd.fetch)
            begin
                out_none_reg <= !has_beat;
                out_last_reg <= has_beat && ((read_ptr_reg + FCW'(1)) == beat_count_reg);
                if (has_beat)
                begin
                    read_ptr_reg <= read_ptr_reg + FCW'(1);
                end
            end
        end
    end

    // scan payload registers
    always_ff @(posedge clk)
    begin
        rd_j_reg <= score_addr;
        if (cmd.frame_init)
        begin
            env_reg      <= request.value;
            j_cur_reg    <= dp_jlo;
            j_end_reg    <= dp_jhi;
            best_val_reg <= '0;
        end
        if (cmd.tail_init)
        begin
            j_cur_reg <= FW'(tail_start);
            j_end_reg <= last_idx;
        end
        if (cmd.scan_issue)
        begin
            j_cur_reg <= j_cur_reg + FW'(1);
        end
        if (take)
        begin
            best_val_reg <= cand[31:0];
            best_j_reg   <= rd_j_reg;
        end
        if (cmd.bt_start)
        begin
            bt_p_reg <= best_j_reg;
        end
        if (cmd.bt_next)
        begin
            bt_p_reg <= bp_q[FW-1:0];
        end
    end

    // status to the controller
    assign status.frame_full = (frame_count_reg == FCW'(MAX_FRAMES));
    assign status.scan_empty = scan_empty_reg;
    assign status.scan_end   = (j_cur_reg == j_end_reg);
    assign status.bp_none    = bp_q[FW];

    // fetch result
    assign result_valid      = out_valid_reg;
    assign result.beat_frame = out_none_reg ? 12'd0 : 12'(bl_q);
    assign result.last_beat  = out_last_reg;
    assign result.none_left  = out_none_reg;

endmodule

[hdl/dp_beat_placement.sv]
// a penalty load is written when it is taken; a fetch result shows in the cycle after start
// an envelope sample scans its gap range, one predecessor score per cycle, unless the frame store is full
// the last sample then scans the tail and backtracks from the best frame into the beat list
// loads and fetches are taken back to back; busy is high during frame and track work
// reset is asynchronous: counts clear, configuration takes its defaults, memories keep contents
// results cannot be stalled: each one is on the result ports for exactly one cycle
module dp_beat_placement
    import dpbt_pkg::*;
#(
    parameter int MAX_FRAMES = 4096,
    parameter int MAX_GAP    = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  dpbt_req_t  request,
    output logic       result_valid,
    output dpbt_res_t  result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data
);

    dpbt_cmd_t    cmd;
    dpbt_status_t status;

    // configuration is taken whenever the block is idle
    assign cfg_ready = !busy;

    dpbt_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .status  (status),
        .cmd     (cmd),
        .busy    (busy)
    );

    dpbt_datapath #(
        .MAX_FRAMES (MAX_FRAMES),
        .MAX_GAP    (MAX_GAP)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .request      (request),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

[test/dp_beat_placement_tb.sv]
module dp_beat_placement_tb;
    import dpbt_pkg::*;

    localparam int CLK_PERIOD       = 8;
    localparam int FRAME_DEPTH      = 4096;
    localparam int GAP_DEPTH        = 256;
    localparam int ITEM_TARGET      = 1450;
    localparam int N_DIRECTED       = 22;
    localparam int DIRECTED_CFG_ROW = 5;
    localparam longint SCORE_CEIL   = 64'h0000_0000_FFFF_FFFF;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum int { ENV_RANDOM, ENV_PERIODIC, ENV_FULL_SCALE, ENV_FAINT } env_shape_t;

    // one directed request, with a hand-written answer where typed is set
    typedef struct packed {
        dpbt_req_t req;
        logic      typed;
        dpbt_res_t res;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    dpbt_req_t  request;
    logic       result_valid;
    dpbt_res_t  result;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [8:0] cfg_data;

    // predictor copy of configuration and track state
    logic [7:0]  pred_gap_min;
    logic [7:0]  pred_gap_max;
    logic [8:0]  pred_tail_len;
    logic [23:0] pen_table [GAP_DEPTH];
    logic [31:0] frame_score [FRAME_DEPTH];
    int          frame_back [FRAME_DEPTH];
    logic [11:0] beat_frames [FRAME_DEPTH];
    int          frames_held;
    int          beats_held;
    int          beats_read;

    dpbt_res_t   expected_beats [$];
    int          mismatch_count;
    int          requests_sent;
    int          no_idle_left;

    dp_beat_placement dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    always #(CLK_PERIOD / 2) clk = ~clk;

    // run limit
    initial
    begin
        #(CLK_PERIOD * 6000000);
        $display("TEST FAILED");
        $finish;
    end

    // dp step for one envelope sample
    task automatic score_frame(input logic [23:0] env);
        int     lo;
        int     d;
        int     best_j;
        longint best;
        longint cand;
        longint total;
        lo = (pred_gap_min == 8'd0) ? 1 : int'(pred_gap_min);
        best = 0;
        best_j = -1;
        // walking the gap downward visits predecessors oldest first
        for (d = int'(pred_gap_max); d >= lo; d--)
        begin
            if (d <= frames_held)
            begin
                cand = longint'({32'd0, frame_score[frames_held - d]})
                     - longint'({40'd0, pen_table[d]});
                if (cand > best)
                begin
                    best = cand;
                    best_j = frames_held - d;
                end
            end
        end
        total = longint'({40'd0, env}) + best;
        frame_score[frames_held] = (total > SCORE_CEIL) ? 32'hFFFF_FFFF : total[31:0];
        frame_back[frames_held] = best_j;
        frames_held++;
    endtask

    // pick the final beat in the tail and backtrack into the beat list
    task automatic close_track();
        int n;
        int top;
        int first;
        int i;
        int cnt;
        int k;
        int p;
        n = frames_held;
        beats_held = 0;
        beats_read = 0;
        frames_held = 0;
        if (n > 0)
        begin
            top = n - 1;
            first = (n > int'(pred_tail_len)) ? n - int'(pred_tail_len) : 0;
            for (i = first; i < n; i++)
            begin
                if (frame_score[i] > frame_score[top])
                    top = i;
            end
            cnt = 0;
            p = top;
            while (p >= 0 && cnt < FRAME_DEPTH)
            begin
                cnt++;
                p = frame_back[p];
            end
            k = cnt;
            p = top;
            while (p >= 0 && k > 0)
            begin
                k--;
                beat_frames[k] = p[11:0];
                p = frame_back[p];
            end
            beats_held = cnt;
        end
    endtask

    // expected effect of one accepted request
    task automatic predict_request(input dpbt_req_t r, output logic produces,
                                   output dpbt_res_t res);
        produces = 1'b0;
        res = '0;
        case (r.operation)
            OP_LOAD_PENALTY:
                pen_table[r.gap] = r.value;
            OP_SAMPLE:
            begin
                if (frames_held < FRAME_DEPTH)
                    score_frame(r.value);
                if (r.last)
                    close_track();
            end
            OP_FETCH:
            begin
                produces = 1'b1;
                if (beats_read < beats_held)
                begin
                    res.beat_frame = beat_frames[beats_read];
                    res.last_beat = (beats_read + 1 == beats_held);
                    beats_read++;
                end
                else
                    res.none_left = 1'b1;
            end
            default:
                ;
        endcase
    endtask

    task automatic flag_mismatch(input string what, input dpbt_res_t want,
                                 input dpbt_res_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected frame/last/none %0d/%0b/%0b, got %0d/%0b/%0b",
                     $time, what, want.beat_frame, want.last_beat, want.none_left,
                     got.beat_frame, got.last_beat, got.none_left);
    endtask

    // result check against the oldest expected beat
    always @(posedge clk)
    begin : result_check
        dpbt_res_t want;
        if (rst_n && result_valid)
        begin
            if (expected_beats.size() == 0)
                flag_mismatch("result with nothing expected", '0, result);
            else
            begin
                want = expected_beats.pop_front();
                if (result.beat_frame !== want.beat_frame ||
                    result.last_beat !== want.last_beat ||
                    result.none_left !== want.none_left)
                    flag_mismatch("result fields differ", want, result);
            end
        end
    end

    function automatic dpbt_req_t make_req(input logic [1:0] op, input logic [7:0] gap,
                                           input logic [23:0] value, input logic last);
        dpbt_req_t r;
        r.operation = op;
        r.gap = gap;
        r.value = value;
        r.last = last;
        return r;
    endfunction

    // sender gap: mostly none, a few long, with bursts of none at all
    function automatic int pick_idle();
        int r;
        if (no_idle_left > 0)
        begin
            no_idle_left--;
            return 0;
        end
        r = $urandom_range(0, 199);
        if (r < 4)
        begin
            no_idle_left = $urandom_range(10, 80);
            return 0;
        end
        if (r < 120)
            return 0;
        if (r < 180)
            return $urandom_range(1, 3);
        if (r < 194)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // called and returns at a falling edge
    task automatic send_request(input dpbt_req_t r, input logic typed,
                                input dpbt_res_t typed_res);
        int        idle;
        logic      produces;
        dpbt_res_t res;
        idle = pick_idle();
        if (idle > 0)
        begin
            start <= 1'b0;
            repeat (idle) @(negedge clk);
        end
        start   <= 1'b1;
        request <= r;
        // hold the request until the block takes it
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_request(r, produces, res);
        if (typed)
            res = typed_res;
        if (produces)
            expected_beats = {expected_beats, res};
        if (r.operation != OP_UNUSED)
            requests_sent++;
        @(negedge clk);
    endtask

    // stop sending and wait out results and any frame or track work
    task automatic drain_block();
        int settle;
        start <= 1'b0;
        while (expected_beats.size() != 0)
            @(negedge clk);
        // samples give no result, so allow for a frame scan and a track close
        settle = 320 + int'(pred_tail_len) + 2 * beats_held;
        repeat (settle) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [8:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_GAP_MIN:  pred_gap_min = data[7:0];
            CFG_GAP_MAX:  pred_gap_max = data[7:0];
            CFG_TAIL_LEN: pred_tail_len = data;
            default:      ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_config(input int gmin, input int gmax, input int tail);
        drain_block();
        cfg_write(CFG_GAP_MIN, 9'(gmin));
        cfg_write(CFG_GAP_MAX, 9'(gmax));
        cfg_write(CFG_TAIL_LEN, 9'(tail));
    endtask

    // quadratic penalty around a center period, clipped to the field
    task automatic load_penalty_curve(input int lo, input int hi, input int center,
                                      input int scale);
        int     i;
        int     d;
        int     span;
        int     n;
        longint v;
        span = hi - lo + 1;
        n = (span > 48) ? 48 : span;
        for (i = 0; i < n; i++)
        begin
            d = (span > 48) ? $urandom_range(lo, hi) : lo + i;
            v = longint'(scale) * (d - center) * (d - center);
            if (v > 64'h00FF_FFFF)
                v = 64'h00FF_FFFF;
            send_request(make_req(OP_LOAD_PENALTY, d[7:0], v[23:0], 1'($urandom)),
                         1'b0, '0);
        end
    endtask

    function automatic logic [23:0] envelope_value(input env_shape_t shape, input int frame,
                                                   input int period);
        logic [23:0] v;
        case (shape)
            ENV_FULL_SCALE:
                v = 24'hFF_FFFF;
            ENV_FAINT:
                v = ($urandom_range(0, 3) == 0) ? 24'd0 : 24'($urandom_range(0, 255));
            ENV_PERIODIC:
            begin
                if (frame % period == 0)
                    v = 24'($urandom_range(24'h40_0000, 24'hFF_FFFF));
                else
                    v = 24'($urandom_range(0, 24'h0F_FFFF));
            end
            default:
                v = 24'($urandom);
        endcase
        return v;
    endfunction

    // one well-formed track with a few stray requests, then read back the beats
    task automatic run_track(input int n, input env_shape_t shape, input int period,
                             input int max_fetch);
        int f;
        int ofs;
        int r;
        int n_fetch;
        int i;
        ofs = $urandom_range(0, period - 1);
        for (f = 0; f < n; f++)
        begin
            r = $urandom_range(0, 99);
            if (r < 2)
                send_request(make_req(OP_FETCH, 8'($urandom), 24'($urandom), 1'($urandom)),
                             1'b0, '0);
            else if (r < 4)
                send_request(make_req(OP_LOAD_PENALTY, 8'($urandom), 24'($urandom),
                                      1'($urandom)), 1'b0, '0);
            else if (r < 5)
                send_request(make_req(OP_UNUSED, 8'($urandom), 24'($urandom), 1'($urandom)),
                             1'b0, '0);
            send_request(make_req(OP_SAMPLE, 8'($urandom),
                                  envelope_value(shape, f + ofs, period), f == n - 1),
                         1'b0, '0);
        end
        // read the list back, sometimes only part of it
        r = $urandom_range(0, 9);
        if (r == 0)
            n_fetch = $urandom_range(0, beats_held);
        else
            n_fetch = beats_held + $urandom_range(0, 2);
        if (n_fetch > max_fetch)
            n_fetch = max_fetch;
        for (i = 0; i < n_fetch; i++)
            send_request(make_req(OP_FETCH, 8'($urandom), 24'($urandom), 1'($urandom)),
                         1'b0, '0);
    endtask

    task automatic random_phase();
        int         gmin;
        int         gmax;
        int         tail;
        int         r;
        int         tracks;
        int         t;
        int         period;
        int         frames;
        int         span;
        int         scale;
        env_shape_t shape;
        r = $urandom_range(0, 9);
        gmin = (r < 4) ? $urandom_range(1, 8) : $urandom_range(1, 60);
        gmax = gmin + $urandom_range(0, 40);
        if (gmax > 255)
            gmax = 255;
        // crossed limits: no predecessor can qualify
        if (r == 9)
        begin
            gmax = $urandom_range(1, 20);
            gmin = gmax + $urandom_range(1, 40);
        end
        r = $urandom_range(0, 5);
        tail = (r == 0) ? 0 : (r == 1) ? 511 : $urandom_range(1, 300);
        set_config(gmin, gmax, tail);
        if (gmin <= gmax)
        begin
            r = $urandom_range(0, 3);
            scale = (r == 0) ? 0 : (r == 1) ? $urandom_range(1, 16) :
                    (r == 2) ? $urandom_range(17, 4096) : 65536;
            load_penalty_curve(gmin, gmax, (gmin + gmax) / 2, scale);
        end
        span = 3 * ((gmax > gmin) ? gmax : gmin) + 10;
        if (span > 220)
            span = 220;
        tracks = $urandom_range(2, 4);
        for (t = 0; t < tracks; t++)
        begin
            r = $urandom_range(0, 9);
            frames = (r < 2) ? $urandom_range(1, 8) : $urandom_range(1, span);
            r = $urandom_range(0, 9);
            shape = (r < 6) ? ENV_PERIODIC : (r < 8) ? ENV_RANDOM :
                    (r == 8) ? ENV_FAINT : ENV_FULL_SCALE;
            period = (gmin <= gmax) ? $urandom_range(gmin, gmax) : $urandom_range(2, 40);
            run_track(frames, shape, period, 64);
        end
    endtask

    // directed requests; typed answers where they are plain to see
    function automatic stim_row_t directed_row(input int idx);
        case (idx)
            // fetch before any track has ended
            0:  return {OP_FETCH, 8'h00, 24'h00_0000, 1'b0, 1'b1, 12'd0, 1'b0, 1'b1};
            // unknown operation, every other field high
            1:  return {OP_UNUSED, 8'hFF, 24'hFF_FFFF, 1'b1, 1'b0, 14'd0};
            // single-frame track
            2:  return {OP_SAMPLE, 8'hFF, 24'h00_0000, 1'b1, 1'b0, 14'd0};
            3:  return {OP_FETCH, 8'h00, 24'h00_0000, 1'b0, 1'b1, 12'd0, 1'b1, 1'b0};
            4:  return {OP_FETCH, 8'hFF, 24'hFF_FFFF, 1'b1, 1'b1, 12'd0, 1'b0, 1'b1};
            // penalty extremes, then a short track over gaps 1 to 3
            5:  return {OP_LOAD_PENALTY, 8'h00, 24'h00_0000, 1'b0, 1'b0, 14'd0};
            6:  return {OP_LOAD_PENALTY, 8'hFF, 24'hFF_FFFF, 1'b1, 1'b0, 14'd0};
            7:  return {OP_LOAD_PENALTY, 8'h01, 24'h00_0000, 1'b0, 1'b0, 14'd0};
            8:  return {OP_LOAD_PENALTY, 8'h02, 24'h00_0100, 1'b0, 1'b0, 14'd0};
            9:  return {OP_LOAD_PENALTY, 8'h03, 24'hFF_FFFF, 1'b0, 1'b0, 14'd0};
            10: return {OP_SAMPLE, 8'h00, 24'hFF_FFFF, 1'b0, 1'b0, 14'd0};
            11: return {OP_SAMPLE, 8'hFF, 24'h00_0000, 1'b0, 1'b0, 14'd0};
            12: return {OP_SAMPLE, 8'h00, 24'h80_0000, 1'b0, 1'b0, 14'd0};
            13: return {OP_SAMPLE, 8'h00, 24'h00_0001, 1'b0, 1'b0, 14'd0};
            14: return {OP_SAMPLE, 8'h00, 24'hFF_FFFF, 1'b0, 1'b0, 14'd0};
            15: return {OP_SAMPLE, 8'h00, 24'h7F_FFFF, 1'b1, 1'b0, 14'd0};
            16: return {OP_FETCH, 8'hFF, 24'hFF_FFFF, 1'b1, 1'b0, 14'd0};
            17: return {OP_FETCH, 8'h00, 24'h00_0000, 1'b0, 1'b0, 14'd0};
            default: return {OP_FETCH, 8'h5A, 24'hA5_5A5A, 1'b1, 1'b0, 14'd0};
        endcase
    endfunction

    // stimulus
    initial
    begin
        int        i;
        int        phase_no;
        int        random_base;
        int        overflow_items;
        stim_row_t row;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pred_gap_min = GAP_MIN_RST;
        pred_gap_max = GAP_MAX_RST;
        pred_tail_len = TAIL_LEN_RST;
        frames_held = 0;
        beats_held = 0;
        beats_read = 0;
        mismatch_count = 0;
        requests_sent = 0;
        no_idle_left = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // fill every penalty entry so no scan ever reads an unwritten one
        for (i = 0; i < GAP_DEPTH; i++)
            send_request(make_req(OP_LOAD_PENALTY, i[7:0], 24'($urandom), 1'($urandom)),
                         1'b0, '0);

        // directed table
        for (i = 0; i < N_DIRECTED; i++)
        begin
            if (i == DIRECTED_CFG_ROW)
                set_config(0, 3, 0);
            row = directed_row(i);
            send_request(row.req, row.typed, row.res);
        end

        // random phases, with the special settings mixed in
        random_base = requests_sent;
        overflow_items = 0;
        phase_no = 0;
        while (phase_no < 8 || requests_sent - random_base - overflow_items < ITEM_TARGET)
        begin
            case (phase_no)
                1:
                begin
                    // score saturation: every frame chains to the one before
                    set_config(1, 1, $urandom_range(0, 511));
                    send_request(make_req(OP_LOAD_PENALTY, 8'd1, 24'd0, 1'b0), 1'b0, '0);
                    run_track(270, ENV_FULL_SCALE, 1, 24);
                end
                3:
                begin
                    // envelope store overflow with no predecessors allowed
                    overflow_items = requests_sent;
                    set_config(255, 1, 511);
                    run_track(FRAME_DEPTH + 6, ENV_RANDOM, 7, 4);
                    overflow_items = requests_sent - overflow_items;
                end
                5:
                begin
                    // widest scan window
                    set_config(1, 255, 511);
                    load_penalty_curve(1, 255, $urandom_range(20, 120),
                                       $urandom_range(1, 64));
                    run_track($urandom_range(20, 40), ENV_PERIODIC, $urandom_range(20, 80), 32);
                    run_track($urandom_range(20, 40), ENV_RANDOM, 40, 32);
                end
                7:
                begin
                    // longest single gap only
                    set_config(255, 255, $urandom_range(0, 511));
                    send_request(make_req(OP_LOAD_PENALTY, 8'd255, 24'($urandom_range(0, 4096)),
                                          1'b0), 1'b0, '0);
                    run_track(262, ENV_RANDOM, 255, 8);
                end
                default:
                    random_phase();
            endcase
            phase_no++;
        end

        drain_block();
        if (mismatch_count == 0 && expected_beats.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
